// File: hdl/cstretch_pkg.sv
// Shared constants and types of the min/max contrast stretch block.
package cstretch_pkg;

  // Frame capacity in pixels.
  localparam int unsigned FRAME_PIXELS = 65536;

  // Store address and fill count widths; the count can hold the capacity itself.
  localparam int unsigned ADDR_W = $clog2(FRAME_PIXELS);
  localparam int unsigned CNT_W  = $clog2(FRAME_PIXELS + 1);

  // Pixel and stretch arithmetic widths.
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned NUM_W  = 2 * PIX_W;
  localparam int unsigned STEP_W = $clog2(PIX_W);

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_PIXELS);
  localparam logic [PIX_W-1:0] PIX_MAX   = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_ZERO  = '0;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_HOLD
  } state_e;

endpackage

// File: hdl/cstretch_if.sv
// Valid/ready channel interfaces for the contrast stretch block.
interface cstretch_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [cstretch_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, cmd, pixel_in, input ready);
  modport sink   (input valid, cmd, pixel_in, output ready);
endinterface

interface cstretch_out_if;
  logic                          valid;
  logic                          ready;
  logic [cstretch_pkg::PIX_W-1:0] pixel_out;
  logic                          last_pixel;
  logic                          overflowed;
  logic                          empty_res;

  modport source (output valid, pixel_out, last_pixel, overflowed, empty_res, input ready);
  modport sink   (input valid, pixel_out, last_pixel, overflowed, empty_res, output ready);
endinterface

// File: hdl/cstretch_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit a pixel.
module cstretch_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cstretch_pkg::NUM_W-1:0]  dividend_i,
  input  logic [cstretch_pkg::PIX_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [cstretch_pkg::PIX_W-1:0]  quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [cstretch_pkg::STEP_W-1:0]  step_q, step_d;
  logic [cstretch_pkg::PIX_W-1:0]   rem_q, rem_d;
  logic [cstretch_pkg::PIX_W-1:0]   low_q, low_d;
  logic [cstretch_pkg::PIX_W-1:0]   dvs_q;
  logic [cstretch_pkg::PIX_W:0]     trial;
  logic                             fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  // low_q holds the remaining dividend bits and collects quotient bits from the bottom.
  always_comb begin
    trial  = {rem_q, low_q[cstretch_pkg::PIX_W-1]};
    fits   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    low_d  = low_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = dividend_i[cstretch_pkg::NUM_W-1:cstretch_pkg::PIX_W];
      low_d  = dividend_i[cstretch_pkg::PIX_W-1:0];
    end else if (busy_q) begin
      rem_d  = fits ? cstretch_pkg::PIX_W'(trial - {1'b0, dvs_q})
                    : trial[cstretch_pkg::PIX_W-1:0];
      low_d  = {low_q[cstretch_pkg::PIX_W-2:0], fits};
      step_d = step_q + cstretch_pkg::STEP_W'(1);
      if (step_q == cstretch_pkg::STEP_W'(cstretch_pkg::PIX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = low_q;

endmodule

// File: hdl/contrast_stretch_frame.sv
// Top level: frame store, min/max tracking and stretched read-out of one 8-bit frame.
//
// Loads (cmd 0) go straight into a single-port frame memory of FRAME_PIXELS bytes,
// addressed by the fill count, while the darkest and brightest values are tracked; loads
// into a full store are dropped and flagged on every later fetch result of the frame. A
// fetch (cmd 1) reads the next pixel in load order from the registered read port, then
// computes floor(255*(p-min)/(max-min)) in a restoring divider that yields one quotient bit
// per cycle; an empty fetch or a flat frame skips the divider. The divider sets the fetch
// rate unless the output register is still held. A finished result sits in an output
// register so the next item is taken while it waits. After the last stored pixel is
// fetched the frame state clears; the store itself needs no clearing pass.
module contrast_stretch_frame (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  cstretch_in_if.sink             in_i,
  cstretch_out_if.source          out_o
);

  // Frame memory and its registered read port.
  logic [cstretch_pkg::PIX_W-1:0] frame_mem [cstretch_pkg::FRAME_PIXELS];
  logic [cstretch_pkg::PIX_W-1:0] mem_rdata_q;

  // Frame state.
  logic [cstretch_pkg::CNT_W-1:0] count_q;
  logic [cstretch_pkg::CNT_W-1:0] rd_ptr_q;
  logic [cstretch_pkg::PIX_W-1:0] min_q;
  logic [cstretch_pkg::PIX_W-1:0] max_q;
  logic                           ovf_q;

  // Per-fetch job state.
  cstretch_pkg::state_e state_q, state_d;
  logic [cstretch_pkg::PIX_W-1:0] job_min_q;
  logic [cstretch_pkg::PIX_W-1:0] job_range_q;
  logic                           job_flat_q;
  logic                           job_last_q;
  logic                           job_ovf_q;
  logic                           job_empty_q;
  logic [cstretch_pkg::PIX_W-1:0] res_pix_q;

  // Output register.
  logic                           out_valid_q;
  logic [cstretch_pkg::PIX_W-1:0] out_pix_q;
  logic                           out_last_q;
  logic                           out_ovf_q;
  logic                           out_empty_q;

  // Strobes from the sequencer.
  logic in_fire, do_load, do_fetch, div_start, push_out, out_free;
  logic full, fetch_empty, fetch_last;
  logic [cstretch_pkg::PIX_W-1:0] diff;
  logic [cstretch_pkg::NUM_W-1:0] numer;
  logic                           div_done;
  logic [cstretch_pkg::PIX_W-1:0] div_quot;

  assign full        = (count_q == cstretch_pkg::FRAME_CNT);
  assign fetch_empty = (rd_ptr_q >= count_q);
  assign fetch_last  = ((rd_ptr_q + cstretch_pkg::CNT_W'(1)) == count_q);
  assign out_free    = !out_valid_q || out_o.ready;

  // 255 * (p - min) as (d << 8) - d.
  assign diff  = mem_rdata_q - job_min_q;
  assign numer = {diff, cstretch_pkg::PIX_ZERO} - {cstretch_pkg::PIX_ZERO, diff};

  cstretch_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numer),
    .divisor_i  (job_range_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer: next state and strobes.
  always_comb begin
    state_d   = state_q;
    in_i.ready = 1'b0;
    in_fire   = 1'b0;
    do_load   = 1'b0;
    do_fetch  = 1'b0;
    div_start = 1'b0;
    push_out  = 1'b0;
    unique case (state_q)
      cstretch_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        in_fire    = in_i.valid;
        if (in_fire) begin
          if (in_i.cmd == cstretch_pkg::CMD_LOAD) begin
            do_load = 1'b1;
          end else begin
            do_fetch = 1'b1;
            state_d  = fetch_empty ? cstretch_pkg::ST_HOLD : cstretch_pkg::ST_READ;
          end
        end
      end
      cstretch_pkg::ST_READ: begin
        if (job_flat_q) begin
          state_d = cstretch_pkg::ST_HOLD;
        end else begin
          div_start = 1'b1;
          state_d   = cstretch_pkg::ST_DIV;
        end
      end
      cstretch_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = cstretch_pkg::ST_HOLD;
        end
      end
      cstretch_pkg::ST_HOLD: begin
        if (out_free) begin
          push_out = 1'b1;
          state_d  = cstretch_pkg::ST_IDLE;
        end
      end
      default: state_d = cstretch_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cstretch_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame state: append on load, advance or clear on fetch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= '0;
      min_q    <= cstretch_pkg::PIX_MAX;
      max_q    <= cstretch_pkg::PIX_ZERO;
      ovf_q    <= 1'b0;
    end else if (do_load) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + cstretch_pkg::CNT_W'(1);
        if (in_i.pixel_in < min_q) begin
          min_q <= in_i.pixel_in;
        end
        if (in_i.pixel_in > max_q) begin
          max_q <= in_i.pixel_in;
        end
      end
    end else if (do_fetch && !fetch_empty) begin
      if (fetch_last) begin
        count_q  <= '0;
        rd_ptr_q <= '0;
        min_q    <= cstretch_pkg::PIX_MAX;
        max_q    <= cstretch_pkg::PIX_ZERO;
        ovf_q    <= 1'b0;
      end else begin
        rd_ptr_q <= rd_ptr_q + cstretch_pkg::CNT_W'(1);
      end
    end
  end

  // Frame memory: write on load, registered read on fetch.
  always_ff @(posedge clk_i) begin
    if (do_load && !full) begin
      frame_mem[count_q[cstretch_pkg::ADDR_W-1:0]] <= in_i.pixel_in;
    end
    if (do_fetch) begin
      mem_rdata_q <= frame_mem[rd_ptr_q[cstretch_pkg::ADDR_W-1:0]];
    end
  end

  // Job snapshot at fetch, result capture.
  always_ff @(posedge clk_i) begin
    if (do_fetch) begin
      job_min_q   <= min_q;
      job_range_q <= max_q - min_q;
      job_flat_q  <= (max_q <= min_q);
      job_last_q  <= !fetch_empty && fetch_last;
      job_ovf_q   <= ovf_q;
      job_empty_q <= fetch_empty;
      res_pix_q   <= cstretch_pkg::PIX_ZERO;
    end else if (state_q == cstretch_pkg::ST_READ && job_flat_q) begin
      res_pix_q <= cstretch_pkg::PIX_ZERO;
    end else if (state_q == cstretch_pkg::ST_DIV && div_done) begin
      res_pix_q <= div_quot;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_out) begin
      out_pix_q   <= res_pix_q;
      out_last_q  <= job_last_q;
      out_ovf_q   <= job_ovf_q;
      out_empty_q <= job_empty_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_out  = out_pix_q;
  assign out_o.last_pixel = out_last_q;
  assign out_o.overflowed = out_ovf_q;
  assign out_o.empty_res  = out_empty_q;

  // Checks.
  a_ptr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= count_q)
    else $error("read pointer beyond fill count");

  a_clear_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> (min_q == cstretch_pkg::PIX_MAX && max_q == cstretch_pkg::PIX_ZERO
                       && !ovf_q))
    else $error("empty frame with stale min/max/overflow");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flagged with room left");

  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q)
    else $error("min above max in a non-empty frame");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == cstretch_pkg::ST_DIV)
    else $error("divider finished outside divide state");

endmodule
